>>> rtl/core/cordic_cart_to_polar_top_assert.svh
// Assertion macros for the Cartesian-to-polar converter.
// They sample on aclk and are disabled while aresetn is low.
`ifndef CORDIC_CART_TO_POLAR_TOP_ASSERT_SVH
`define CORDIC_CART_TO_POLAR_TOP_ASSERT_SVH

// The consequent holds in the same cycle as the antecedent.
`define CC2P_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("cc2p assertion failed");

// The consequent holds in the cycle after the antecedent.
`define CC2P_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("cc2p assertion failed");

`endif

>>> rtl/core/cc2p_pkg.sv
package cc2p_pkg;

    localparam int ITERATIONS     = 16;
    localparam int DATA_WIDTH     = 16;
    localparam int INTERNAL_WIDTH = 20;

    localparam int ANG_FRAC   = 24;
    localparam int ANG_W      = 28;
    localparam int TABLE_LEN  = 24;
    localparam int GAIN_W     = 24;
    localparam int PROD_W     = INTERNAL_WIDTH + GAIN_W;
    localparam int PHASE_FRAC = DATA_WIDTH - 3;
    localparam int PH_SHIFT   = ANG_FRAC - PHASE_FRAC;

    localparam int HALF_PI_Q24  = 26353589;
    localparam int PI_Q24       = 52707179;
    localparam int INV_GAIN_Q24 = 10188014;
    localparam int PHASE_LIM_I  = (PI_Q24 + (1 << (PH_SHIFT - 1))) >> PH_SHIFT;

    localparam logic [GAIN_W-1:0]       INV_GAIN  = GAIN_W'(INV_GAIN_Q24);
    localparam logic signed [ANG_W-1:0] PHASE_LIM = ANG_W'(PHASE_LIM_I);
    localparam logic signed [ANG_W-1:0] PH_HALF   = ANG_W'(1 << (PH_SHIFT - 1));
    localparam logic [PROD_W-1:0]       MAG_HALF  = PROD_W'(1) << (ANG_FRAC - 1);

    localparam logic signed [ANG_W-1:0] ATAN_Q24 [TABLE_LEN] = '{
        ANG_W'(13176795), ANG_W'(7778716), ANG_W'(4110060), ANG_W'(2086331),
        ANG_W'(1047214), ANG_W'(524117), ANG_W'(262123), ANG_W'(131069),
        ANG_W'(65536), ANG_W'(32768), ANG_W'(16384), ANG_W'(8192),
        ANG_W'(4096), ANG_W'(2048), ANG_W'(1024), ANG_W'(512),
        ANG_W'(256), ANG_W'(128), ANG_W'(64), ANG_W'(32),
        ANG_W'(16), ANG_W'(8), ANG_W'(4), ANG_W'(2)
    };

    typedef enum logic [1:0] {
        QUAD_NONE,
        QUAD_POS_HALF,
        QUAD_NEG_PI,
        QUAD_NEG_HALF
    } quad_t;

    typedef struct packed {
        logic                               valid;
        quad_t                              quad;
        logic signed [INTERNAL_WIDTH-1:0]   x;
        logic signed [INTERNAL_WIDTH-1:0]   y;
        logic signed [ANG_W-1:0]            ang;
    } rot_t;

    function automatic logic signed [ANG_W-1:0] quad_offset(input quad_t q);
        logic signed [ANG_W-1:0] off;
        unique case (q)
            QUAD_NONE:     off = '0;
            QUAD_POS_HALF: off = ANG_W'(HALF_PI_Q24);
            QUAD_NEG_PI:   off = -ANG_W'(PI_Q24);
            QUAD_NEG_HALF: off = -ANG_W'(HALF_PI_Q24);
            default:       off = '0;
        endcase
        return off;
    endfunction

endpackage

>>> rtl/core/cc2p_quadrant.sv
module cc2p_quadrant (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 enable,
    input  logic                                 in_valid,
    input  logic signed [cc2p_pkg::DATA_WIDTH-1:0] x_coord,
    input  logic signed [cc2p_pkg::DATA_WIDTH-1:0] y_coord,
    output cc2p_pkg::rot_t                       stage_o
);
    import cc2p_pkg::*;

    localparam int IW = INTERNAL_WIDTH;
    localparam int DW = DATA_WIDTH;

    logic signed [IW-1:0] x_ext;
    logic signed [IW-1:0] y_ext;
    logic                 x_neg;
    logic                 y_pos;
    rot_t                 stage_reg;
    rot_t                 stage_next;

    assign x_ext = {{(IW - DW){x_coord[DW-1]}}, x_coord};
    assign y_ext = {{(IW - DW){y_coord[DW-1]}}, y_coord};
    assign x_neg = x_coord[DW-1];
    assign y_pos = !y_coord[DW-1] && (y_coord != '0);

    always_comb begin
        stage_next.valid = in_valid;
        stage_next.ang   = '0;
        priority if (x_neg && y_pos) begin
            stage_next.x    = y_ext;
            stage_next.y    = -x_ext;
            stage_next.quad = QUAD_POS_HALF;
        end else if (x_neg) begin
            stage_next.x    = -x_ext;
            stage_next.y    = -y_ext;
            stage_next.quad = QUAD_NEG_PI;
        end else if (!y_pos) begin
            stage_next.x    = -y_ext;
            stage_next.y    = x_ext;
            stage_next.quad = QUAD_NEG_HALF;
        end else begin
            stage_next.x    = x_ext;
            stage_next.y    = y_ext;
            stage_next.quad = QUAD_NONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_reg.valid <= 1'b0;
        end else if (enable) begin
            stage_reg <= stage_next;
        end
    end

    assign stage_o = stage_reg;

endmodule

>>> rtl/core/cc2p_rotator.sv
module cc2p_rotator (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           enable,
    input  cc2p_pkg::rot_t stage_i,
    output cc2p_pkg::rot_t stage_o
);
    import cc2p_pkg::*;

    localparam int IW = INTERNAL_WIDTH;

    rot_t pipe_reg [ITERATIONS];

    for (genvar i = 0; i < ITERATIONS; i++) begin : g_stage
        rot_t                 src;
        rot_t                 pipe_next;
        logic signed [IW-1:0] xs;
        logic signed [IW-1:0] ys;
        logic                 y_pos;

        if (i == 0) begin : g_first
            assign src = stage_i;
        end else begin : g_rest
            assign src = pipe_reg[i-1];
        end

        assign xs    = $signed(src.x) >>> i;
        assign ys    = $signed(src.y) >>> i;
        assign y_pos = !src.y[IW-1] && (src.y != '0);

        always_comb begin
            pipe_next = src;
            if (y_pos) begin
                pipe_next.x   = src.x + ys;
                pipe_next.y   = src.y - xs;
                pipe_next.ang = src.ang + ATAN_Q24[i];
            end else begin
                pipe_next.x   = src.x - ys;
                pipe_next.y   = src.y + xs;
                pipe_next.ang = src.ang - ATAN_Q24[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                pipe_reg[i].valid <= 1'b0;
            end else if (enable) begin
                pipe_reg[i] <= pipe_next;
            end
        end
    end

    assign stage_o = pipe_reg[ITERATIONS-1];

endmodule

>>> rtl/core/cc2p_scale.sv
module cc2p_scale (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   enable,
    input  cc2p_pkg::rot_t                         stage_i,
    output logic                                   out_valid,
    output logic [cc2p_pkg::DATA_WIDTH-1:0]        magnitude,
    output logic signed [cc2p_pkg::DATA_WIDTH-1:0] phase
);
    import cc2p_pkg::*;

    localparam int IW = INTERNAL_WIDTH;
    localparam int DW = DATA_WIDTH;

    logic                    mul_valid_reg;
    logic [PROD_W-1:0]       prod_reg;
    logic [PROD_W-1:0]       prod_next;
    logic signed [ANG_W-1:0] ang_reg;
    logic signed [ANG_W-1:0] ang_next;

    logic                    out_valid_reg;
    logic [DW-1:0]           mag_reg;
    logic [DW-1:0]           mag_next;
    logic signed [DW-1:0]    phase_reg;
    logic signed [DW-1:0]    phase_next;

    logic                    x_pos;
    logic [PROD_W-1:0]       prod_rnd;
    logic [IW-1:0]           mag_full;
    logic signed [ANG_W-1:0] ang_rnd;
    logic signed [ANG_W-1:0] ang_sat;

    assign x_pos     = !stage_i.x[IW-1] && (stage_i.x != '0);
    assign prod_next = x_pos ? (PROD_W'(unsigned'(stage_i.x)) * PROD_W'(INV_GAIN)) : '0;
    assign ang_next  = stage_i.ang + quad_offset(stage_i.quad);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_valid_reg <= 1'b0;
        end else if (enable) begin
            mul_valid_reg <= stage_i.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (enable) begin
            prod_reg <= prod_next;
            ang_reg  <= ang_next;
        end
    end

    assign prod_rnd = prod_reg + MAG_HALF;
    assign mag_full = prod_rnd[ANG_FRAC +: IW];
    assign mag_next = (|mag_full[IW-1:DW]) ? '1 : mag_full[DW-1:0];

    assign ang_rnd = $signed(ang_reg + PH_HALF) >>> PH_SHIFT;

    always_comb begin
        priority if (ang_rnd > PHASE_LIM) begin
            ang_sat = PHASE_LIM;
        end else if (ang_rnd < -PHASE_LIM) begin
            ang_sat = -PHASE_LIM;
        end else begin
            ang_sat = ang_rnd;
        end
    end

    assign phase_next = ang_sat[DW-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (enable) begin
            out_valid_reg <= mul_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (enable) begin
            mag_reg   <= mag_next;
            phase_reg <= phase_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign magnitude = mag_reg;
    assign phase     = phase_reg;

endmodule

>>> rtl/core/cordic_cart_to_polar_top.sv
// Cartesian-to-polar converter: each transaction carries a signed Q2.14 point and
// returns its magnitude (unsigned Q2.14, CORDIC gain removed) and its angle (signed
// Q3.13 radians, saturated to [-pi, pi]; the negative x axis and the origin give -pi).
// The pipeline takes one transaction per clock while no result is held at the output;
// its stages are one quadrant stage, one stage per shift-add micro-rotation, one stage
// for the gain multiply and angle offset, and the output register. When a result is
// held at the output, the whole pipeline freezes, empty slots included, and s_ready
// drops until that result is taken.
module cordic_cart_to_polar_top (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic signed [cc2p_pkg::DATA_WIDTH-1:0] s_x_coord,
    input  logic signed [cc2p_pkg::DATA_WIDTH-1:0] s_y_coord,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic [cc2p_pkg::DATA_WIDTH-1:0]        m_magnitude,
    output logic signed [cc2p_pkg::DATA_WIDTH-1:0] m_phase
);
    import cc2p_pkg::*;

    logic enable;
    rot_t quad_stage;
    rot_t rot_stage;

    assign enable  = !m_valid || m_ready;
    assign s_ready = enable;

    cc2p_quadrant u_quadrant (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .enable   (enable),
        .in_valid (s_valid),
        .x_coord  (s_x_coord),
        .y_coord  (s_y_coord),
        .stage_o  (quad_stage)
    );

    cc2p_rotator u_rotator (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .enable   (enable),
        .stage_i  (quad_stage),
        .stage_o  (rot_stage)
    );

    cc2p_scale u_scale (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .enable    (enable),
        .stage_i   (rot_stage),
        .out_valid (m_valid),
        .magnitude (m_magnitude),
        .phase     (m_phase)
    );

`include "cordic_cart_to_polar_top_assert.svh"

    `CC2P_ASSERT_NOW(a_phase_range, m_valid, (m_phase <= PHASE_LIM) && (m_phase >= -PHASE_LIM))
    `CC2P_ASSERT_NOW(a_drain_accepts, m_valid && m_ready, s_ready)
    `CC2P_ASSERT_NEXT(a_stall_freezes, !s_ready, $stable(quad_stage.valid) && $stable(rot_stage.valid) && m_valid)

endmodule

>>> sim/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import cc2p_pkg::*;

    localparam int     DW            = cc2p_pkg::DATA_WIDTH;
    localparam int     LANE_W        = 20;
    localparam int     MICRO_STEPS   = 16;
    localparam int     GAIN_FRAC     = 24;
    localparam int     PHASE_SHIFT   = 11;
    localparam longint ANGLE_HALF_PI = 26353589;
    localparam longint ANGLE_PI      = 52707179;
    localparam longint GAIN_RECIP    = 10188014;
    localparam longint PHASE_ROUND   = 1 << (PHASE_SHIFT - 1);
    localparam longint PHASE_MAX     = (ANGLE_PI + PHASE_ROUND) >>> PHASE_SHIFT;
    localparam longint MAG_MAX       = (1 << DW) - 1;
    localparam int     RANDOM_POINTS = 1030;
    localparam int     CALM_TAIL     = 150;
    localparam int     DRAIN_CYCLES  = 40;
    localparam int     CYCLE_LIMIT   = 300000;

    localparam longint ARCTAN [MICRO_STEPS] = '{
        13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
        65536, 32768, 16384, 8192, 4096, 2048, 1024, 512
    };

    typedef struct {
        logic [DW-1:0]        magnitude;
        logic signed [DW-1:0] phase;
    } polar_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic signed [DW-1:0] s_x_coord;
    logic signed [DW-1:0] s_y_coord;
    logic                 m_valid;
    logic                 m_ready;
    logic [DW-1:0]        m_magnitude;
    logic signed [DW-1:0] m_phase;

    bit calm;
    bit src_gaps;
    bit sink_gaps;
    int cycle_count;

    function automatic longint wrap_lane(input longint v);
        logic signed [LANE_W-1:0] t;
        t = v[LANE_W-1:0];
        return t;
    endfunction

    function automatic polar_t to_polar(input logic signed [DW-1:0] x,
                                        input logic signed [DW-1:0] y);
        longint xv, yv, xi, yi, xn, yn, ang, mag, ph;
        quad_t  quad;
        polar_t r;
        xv = x;
        yv = y;
        if (xv < 0 && yv > 0) begin
            xi = yv;
            yi = -xv;
            quad = QUAD_POS_HALF;
        end else if (xv < 0) begin
            xi = -xv;
            yi = -yv;
            quad = QUAD_NEG_PI;
        end else if (yv <= 0) begin
            xi = -yv;
            yi = xv;
            quad = QUAD_NEG_HALF;
        end else begin
            xi = xv;
            yi = yv;
            quad = QUAD_NONE;
        end
        xi = wrap_lane(xi);
        yi = wrap_lane(yi);
        ang = 0;
        for (int i = 0; i < MICRO_STEPS; i++) begin
            if (yi > 0) begin
                ang += ARCTAN[i];
                xn = xi + (yi >>> i);
                yn = yi - (xi >>> i);
            end else begin
                ang -= ARCTAN[i];
                xn = xi - (yi >>> i);
                yn = yi + (xi >>> i);
            end
            xi = wrap_lane(xn);
            yi = wrap_lane(yn);
        end
        case (quad)
            QUAD_POS_HALF: ang += ANGLE_HALF_PI;
            QUAD_NEG_PI:   ang -= ANGLE_PI;
            QUAD_NEG_HALF: ang -= ANGLE_HALF_PI;
            default:       ang += 0;
        endcase
        if (xi <= 0)
            mag = 0;
        else
            mag = (xi * GAIN_RECIP + (longint'(1) << (GAIN_FRAC - 1))) >>> GAIN_FRAC;
        if (mag > MAG_MAX)
            mag = MAG_MAX;
        ph = (ang + PHASE_ROUND) >>> PHASE_SHIFT;
        if (ph > PHASE_MAX)
            ph = PHASE_MAX;
        if (ph < -PHASE_MAX)
            ph = -PHASE_MAX;
        r.magnitude = mag[DW-1:0];
        r.phase = ph[DW-1:0];
        return r;
    endfunction

    class polar_ledger;
        polar_t pending[$];
        int     errors;

        function void note_point(input logic signed [DW-1:0] x,
                                 input logic signed [DW-1:0] y);
            pending.push_back(to_polar(x, y));
        endfunction

        function void check_polar(input logic [DW-1:0] magnitude,
                                  input logic signed [DW-1:0] phase);
            polar_t want;
            if (pending.size() == 0) begin
                $error("unexpected result: magnitude %0d phase %0d", magnitude, phase);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (magnitude !== want.magnitude) begin
                $error("magnitude: expected %0d, actual %0d", want.magnitude, magnitude);
                errors++;
            end
            if (phase !== want.phase) begin
                $error("phase: expected %0d, actual %0d", want.phase, phase);
                errors++;
            end
        endfunction
    endclass

    polar_ledger ledger;

    cordic_cart_to_polar_top dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_x_coord   (s_x_coord),
        .s_y_coord   (s_y_coord),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_magnitude (m_magnitude),
        .m_phase     (m_phase)
    );

    initial aclk = 1'b0;
    always #10 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    task automatic send_point(input logic signed [DW-1:0] x, input logic signed [DW-1:0] y);
        if (!calm && src_gaps && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_x_coord <= x;
        s_y_coord <= y;
        do
            @(posedge aclk);
        while (!(s_valid && s_ready));
        ledger.note_point(x, y);
    endtask

    task automatic random_point(output logic signed [DW-1:0] x,
                                output logic signed [DW-1:0] y);
        case ($urandom_range(0, 3))
            0: begin
                x = 16'($urandom);
                y = 16'($urandom);
            end
            1: begin
                x = $signed(16'($urandom_range(0, 255))) - 16'sd128;
                y = $signed(16'($urandom_range(0, 255))) - 16'sd128;
            end
            2: begin
                x = $signed(16'($urandom_range(0, 2))) - 16'sd1;
                y = 16'($urandom);
                if ($urandom_range(0, 1) == 1) begin
                    y = x;
                    x = 16'($urandom);
                end
            end
            default: begin
                x = $urandom_range(0, 1) ? 16'sh7fff - 16'($urandom_range(0, 3))
                                         : 16'sh8000 + 16'($urandom_range(0, 3));
                y = 16'($urandom);
            end
        endcase
    endtask

    always @(posedge aclk) begin : result_sink
        int stall_left;
        if (aresetn && m_valid && m_ready)
            ledger.check_polar(m_magnitude, m_phase);
        if (!calm && sink_gaps && stall_left == 0 && $urandom_range(0, 3) == 0)
            stall_left = $urandom_range(1, 11);
        if (calm)
            stall_left = 0;
        if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left--;
        end else begin
            m_ready <= 1'b1;
        end
    end

    initial begin : stimulus
        logic signed [DW-1:0] dx [$];
        logic signed [DW-1:0] dy [$];
        logic signed [DW-1:0] x, y;
        ledger = new;
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_x_coord <= '0;
        s_y_coord <= '0;
        m_ready <= 1'b0;
        src_gaps = 1'b1;
        sink_gaps = 1'b1;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // The origin, the four axes, the diagonals, the corners and each quadrant border.
        dx = '{0, 16'sh7fff, 16'sh8000, 0, 0, 1, -1, 0, 0, 16'sh7fff, 16'sh8000,
               16'sh8000, 16'sh7fff, 1, -1, -1, 1, 16'sh8000, -1, 5000, -5000, 12345};
        dy = '{0, 0, 0, 16'sh7fff, 16'sh8000, 0, 0, 1, -1, 16'sh7fff, 16'sh8000,
               16'sh7fff, 16'sh8000, 1, 1, -1, -1, 1, 16'sh8000, -5000, 5000, -54};
        foreach (dx[i])
            send_point(dx[i], dy[i]);

        for (int n = 0; n < RANDOM_POINTS; n++) begin
            if (n % 64 == 0) begin
                src_gaps = $urandom_range(0, 2) != 0;
                sink_gaps = $urandom_range(0, 2) != 0;
            end
            calm = n >= RANDOM_POINTS - CALM_TAIL;
            random_point(x, y);
            send_point(x, y);
        end
        s_valid <= 1'b0;

        while (ledger.pending.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (ledger.errors == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
